// ----- rtl/vsm_pkg.sv -----
// vsm_pkg: shared codes, field widths and the control/status structs
// used by the voice_sample_mixer controller and datapath; no dependencies

package vsm_pkg;

    localparam int FUNC_W   = 2;
    localparam int FIELD_W  = 16;
    localparam int CHAN_W   = 2;
    localparam int STATUS_W = 2;
    localparam int ACTIVE_W = 6;
    localparam int S_DATA_W = 88;
    localparam int M_DATA_W = 40;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_STOP  = 2'd2,
        FUNC_TICK  = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE    = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_NO_CLIP = 2'd2
    } status_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic load_wr;
        logic start_wr;
        logic walk_init;
        logic stop_step;
        logic skip;
        logic read_left;
        logic read_right;
        logic voice_step;
        logic commit_count;
        logic out_load;
    } vsm_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        func_t func;
        logic  more;
        logic  match;
        logic  playing;
        logic  out_free;
    } vsm_sts_t;

endpackage

// ----- rtl/vsm_ram.sv -----
// vsm_ram: generic single-port ram with registered read
// no dependencies

module vsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- rtl/vsm_ctrl.sv -----
// vsm_ctrl: item sequencer for load, start, stop and the tick voice walk
// depends on vsm_pkg

module vsm_ctrl
    import vsm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  vsm_sts_t sts,
    output vsm_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_STOP_SCAN,
        ST_T_CHECK,
        ST_T_RIGHT,
        ST_T_DONE,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (sts.func)
                    FUNC_LOAD:
                    begin
                        cmd.load_wr = 1'b1;
                        state_next  = ST_FINISH;
                    end
                    FUNC_START:
                    begin
                        cmd.start_wr = 1'b1;
                        state_next   = ST_FINISH;
                    end
                    FUNC_STOP:
                    begin
                        cmd.walk_init = 1'b1;
                        state_next    = ST_STOP_SCAN;
                    end
                    FUNC_TICK:
                    begin
                        cmd.walk_init = 1'b1;
                        state_next    = ST_T_CHECK;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_STOP_SCAN:
            begin
                if (!sts.more)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.stop_step = 1'b1;
                    if (sts.match)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_T_CHECK:
            begin
                priority if (!sts.more)
                begin
                    cmd.commit_count = 1'b1;
                    state_next       = ST_FINISH;
                end
                else if (!sts.playing)
                begin
                    cmd.skip = 1'b1;
                end
                else
                begin
                    cmd.read_left = 1'b1;
                    state_next    = ST_T_RIGHT;
                end
            end
            ST_T_RIGHT:
            begin
                cmd.read_right = 1'b1;
                state_next     = ST_T_DONE;
            end
            ST_T_DONE:
            begin
                cmd.voice_step = 1'b1;
                state_next     = ST_T_CHECK;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/vsm_datapath.sv -----
// vsm_datapath: voice table, sample memory, mix accumulators and result register
// depends on vsm_pkg and vsm_ram

module vsm_datapath
    import vsm_pkg::*;
#(
    parameter int VOICES              = 32,
    parameter int SAMPLE_DEPTH        = 65536,
    parameter int PITCH_FRACTION_BITS = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [FUNC_W-1:0]   in_func,
    input  logic [S_DATA_W-1:0] in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [M_DATA_W-1:0] out_data,
    input  vsm_cmd_t            cmd,
    output vsm_sts_t            sts
);

    localparam int PFB  = PITCH_FRACTION_BITS;
    localparam int PW   = FIELD_W + PFB;
    localparam int AW   = $clog2(SAMPLE_DEPTH);
    localparam int SUMW = (AW > 18) ? AW : 18;
    localparam int CW   = $clog2(VOICES + 1);
    localparam int IW   = (VOICES > 1) ? $clog2(VOICES) : 1;

    // captured item
    logic [FUNC_W-1:0]  func_reg;
    logic [FIELD_W-1:0] addr_reg, sval_reg, cstart_reg, clen_reg, pitch_reg;
    logic [CHAN_W-1:0]  cchan_reg;
    logic               loops_reg;

    // voice table
    logic [FIELD_W-1:0] v_start [VOICES];
    logic [FIELD_W-1:0] v_len   [VOICES];
    logic               v_st    [VOICES];
    logic [FIELD_W-1:0] v_rate  [VOICES];
    logic [PW-1:0]      v_pos   [VOICES];
    logic               v_rep   [VOICES];
    logic               v_play  [VOICES];

    logic [CW-1:0]       count_reg, rd_reg, wr_reg;
    logic [FIELD_W-1:0]  left_reg, right_reg, lsamp_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    logic [IW-1:0]      ri, wi, ci;
    logic [FIELD_W-1:0] e_start, e_len, e_rate;
    logic [PW-1:0]      e_pos;
    logic               e_st, e_rep;
    logic [PW:0]        step, sum, lenq, target, thrq;
    logic [17:0]        thr;
    logic               at_end, keep;
    logic [FIELD_W-1:0] lid;
    logic [SUMW-1:0]    laddr, raddr;
    logic [AW-1:0]      ram_addr;
    logic [FIELD_W-1:0] ram_rdata, ldiv, rdiv;
    logic [16:0]        lx, rx;

    assign ri = rd_reg[IW-1:0];
    assign wi = wr_reg[IW-1:0];
    assign ci = count_reg[IW-1:0];

    assign e_start = v_start[ri];
    assign e_len   = v_len[ri];
    assign e_rate  = v_rate[ri];
    assign e_pos   = v_pos[ri];
    assign e_st    = v_st[ri];
    assign e_rep   = v_rep[ri];

    // position advance and end test
    assign step   = e_st ? (PW+1)'({e_rate, 1'b0}) : (PW+1)'(e_rate);
    assign sum    = {1'b0, e_pos} + step;
    assign lenq   = {1'b0, e_len, {PFB{1'b0}}};
    assign target = (sum >= lenq) ? (sum - lenq) : sum;
    assign thr    = {2'b00, e_len} - (e_st ? 18'd3 : 18'd2);
    assign thrq   = {thr[16:0], {PFB{1'b0}}};
    assign at_end = thr[17] || (target >= thrq);
    assign keep   = !at_end || e_rep;

    // sample addresses
    assign lid   = {e_pos[PW-1:PFB+1], e_pos[PFB] & !e_st};
    assign laddr = SUMW'(e_start) + SUMW'(lid) + (e_st ? SUMW'(2) : SUMW'(1));
    assign raddr = SUMW'(e_start) + SUMW'(lid) + (e_st ? SUMW'(3) : SUMW'(1));

    // depth is a power of two, wrap by truncation
    always_comb
    begin
        priority if (cmd.load_wr)
        begin
            ram_addr = AW'(addr_reg);
        end
        else if (cmd.read_right)
        begin
            ram_addr = raddr[AW-1:0];
        end
        else
        begin
            ram_addr = laddr[AW-1:0];
        end
    end

    vsm_ram #(
        .WIDTH (FIELD_W),
        .DEPTH (SAMPLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.load_wr),
        .addr  (ram_addr),
        .wdata (sval_reg),
        .rdata (ram_rdata)
    );

    // divide by channel count, toward zero
    assign lx   = {lsamp_reg[15], lsamp_reg} + 17'(lsamp_reg[15] & e_st);
    assign rx   = {ram_rdata[15], ram_rdata} + 17'(ram_rdata[15] & e_st);
    assign ldiv = e_st ? lx[16:1] : lsamp_reg;
    assign rdiv = e_st ? rx[16:1] : ram_rdata;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg   <= in_func;
            addr_reg   <= in_data[15:0];
            sval_reg   <= in_data[31:16];
            cstart_reg <= in_data[47:32];
            clen_reg   <= in_data[63:48];
            cchan_reg  <= in_data[65:64];
            pitch_reg  <= in_data[81:66];
            loops_reg  <= in_data[82];
        end
        if (cmd.read_right)
        begin
            lsamp_reg <= ram_rdata;
        end
        if (cmd.start_wr && clen_reg != '0 && count_reg < CW'(VOICES))
        begin
            v_start[ci] <= cstart_reg;
            v_len[ci]   <= clen_reg;
            v_st[ci]    <= cchan_reg[1];
            v_rate[ci]  <= pitch_reg;
            v_pos[ci]   <= '0;
            v_rep[ci]   <= loops_reg;
            v_play[ci]  <= 1'b1;
        end
        if (cmd.stop_step && sts.match)
        begin
            v_play[ri] <= 1'b0;
        end
        if (cmd.voice_step && keep)
        begin
            v_start[wi] <= e_start;
            v_len[wi]   <= e_len;
            v_st[wi]    <= e_st;
            v_rate[wi]  <= e_rate;
            v_pos[wi]   <= at_end ? '0 : target[PW-1:0];
            v_rep[wi]   <= e_rep;
            v_play[wi]  <= 1'b1;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= {ACTIVE_W'(count_reg), status_reg, right_reg, left_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_reg        <= '0;
            wr_reg        <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            status_reg    <= STATUS_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                left_reg   <= '0;
                right_reg  <= '0;
                status_reg <= STATUS_DONE;
            end
            if (cmd.start_wr)
            begin
                priority if (clen_reg == '0)
                begin
                    status_reg <= STATUS_NO_CLIP;
                end
                else if (count_reg >= CW'(VOICES))
                begin
                    status_reg <= STATUS_FULL;
                end
                else
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.walk_init)
            begin
                rd_reg <= '0;
                wr_reg <= '0;
            end
            if (cmd.stop_step || cmd.skip)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (cmd.voice_step)
            begin
                rd_reg    <= rd_reg + 1'b1;
                wr_reg    <= wr_reg + CW'(keep);
                left_reg  <= left_reg + ldiv;
                right_reg <= right_reg + rdiv;
            end
            if (cmd.commit_count)
            begin
                count_reg <= wr_reg;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.func     = func_t'(func_reg);
    assign sts.more     = rd_reg < count_reg;
    assign sts.match    = e_start == cstart_reg;
    assign sts.playing  = v_play[ri];
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- rtl/voice_sample_mixer.sv -----
// voice_sample_mixer: top level, joins the sequencer and the datapath
// depends on vsm_pkg, vsm_ctrl, vsm_datapath
//
// channel | dir | handshake        | payload
// s_axis  | in  | s_tvalid/tready  | s_tuser func, s_tdata item fields
// m_axis  | out | m_tvalid/tready  | m_tdata mix, status, active voices
//
// load and start go from dispatch to finish; stop scans up to the first matching voice, or all voices if none match
// tick walks the voices, reading left and right samples of each playing voice and skipping stopped ones
// the single sample ram port (two reads per voice) sets the tick length
// reset clears the voice count and control; table and sample ram are not cleared
// a result held by m_tready low stalls only the end of the next item

module voice_sample_mixer
    import vsm_pkg::*;
#(
    parameter int VOICES              = 32,
    parameter int SAMPLE_DEPTH        = 65536,
    parameter int PITCH_FRACTION_BITS = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // address, sample_value, clip_start, clip_length, clip_channels, pitch, loops
    input  logic [S_DATA_W-1:0] s_tdata,
    // func
    input  logic [FUNC_W-1:0]   s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // left_mix, right_mix, status, active_voices
    output logic [M_DATA_W-1:0] m_tdata
);

    vsm_cmd_t cmd;
    vsm_sts_t sts;

    vsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    vsm_datapath #(
        .VOICES              (VOICES),
        .SAMPLE_DEPTH        (SAMPLE_DEPTH),
        .PITCH_FRACTION_BITS (PITCH_FRACTION_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_func   (s_tuser),
        .in_data   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ----- rtl/vsm_checker.sv -----
// vsm_checker: port-level assertions for voice_sample_mixer, bound to the top
// depends on vsm_pkg and voice_sample_mixer

module vsm_checker
    import vsm_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic [FUNC_W-1:0]   s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item at a time
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while busy");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[33:32] != 2'd3)
        else $error("bad status code");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[39:34] <= 6'd32)
        else $error("voice count out of range");

endmodule

bind voice_sample_mixer vsm_checker u_vsm_checker (.*);
